[design/akx_pkg.sv]
// shared types and constants for the autokey xor frame codec
package akx_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 8192;
    localparam int HDR_BYTES           = 4;
    localparam int LEN_W               = 14;
    localparam int BYTE_W              = 8;

    localparam logic       DIR_ENCRYPT       = 1'b0;
    localparam logic       DIR_DECRYPT       = 1'b1;
    localparam logic [7:0] INITIAL_KEY_RESET = 8'd171;

    // configuration register indexes
    localparam logic REG_DIRECTION   = 1'b0;
    localparam logic REG_INITIAL_KEY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DATA       = 2'd0,
        STATUS_OVER_LIMIT = 2'd1,
        STATUS_EMPTY      = 2'd2
    } status_t;

    // results caused by one input item: optional four header bytes, optional tail item
    typedef struct packed {
        logic              hdr_en;
        logic [LEN_W-1:0]  hdr_len;
        logic              hdr_empty;
        logic              tail_en;
        logic [BYTE_W-1:0] tail_byte;
        logic              tail_last;
        status_t           tail_status;
    } burst_t;

endpackage

[design/akx_core.sv]
// configuration registers, frame state and per-item codec logic
module akx_core #(
    parameter int MAX_PAYLOAD = akx_pkg::MAX_PAYLOAD_DEFAULT,
    parameter int CNT_W       = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [7:0]               cfg_data,
    input  logic                     accept,
    input  logic [7:0]               data_byte,
    input  logic                     frame_start,
    input  logic [akx_pkg::LEN_W-1:0] payload_length,
    output akx_pkg::burst_t          burst
);

    logic             direction_reg;
    logic [7:0]       initial_key_reg;
    logic [7:0]       key_reg, key_next;
    logic [2:0]       hidx_reg, hidx_next;
    logic [31:0]      gather_reg, gather_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             disc_reg, disc_next;

    logic [31:0]      plen_ext;
    logic [31:0]      max_ext;
    logic             plen_over;
    logic [7:0]       eff_key;
    logic [2:0]       eff_hidx;
    logic [31:0]      eff_gather;
    logic [CNT_W-1:0] eff_left;
    logic [31:0]      gather_shift;
    logic             gather_over;
    logic [7:0]       xor_byte;
    logic [CNT_W-1:0] left_dec;
    logic             emit_last;

    assign plen_ext     = {{(32 - akx_pkg::LEN_W){1'b0}}, payload_length};
    assign max_ext      = 32'(MAX_PAYLOAD);
    assign plen_over    = plen_ext > max_ext;
    assign eff_key      = frame_start ? initial_key_reg : key_reg;
    assign eff_hidx     = frame_start ? 3'd0 : hidx_reg;
    assign eff_gather   = frame_start ? 32'd0 : gather_reg;
    assign eff_left     = frame_start ? plen_ext[CNT_W-1:0] : left_reg;
    assign gather_shift = {eff_gather[23:0], data_byte};
    assign gather_over  = gather_shift > max_ext;
    assign xor_byte     = data_byte ^ eff_key;
    assign left_dec     = eff_left - CNT_W'(1);
    assign emit_last    = (left_dec == '0);

    always_comb
    begin
        key_next    = key_reg;
        hidx_next   = hidx_reg;
        gather_next = gather_reg;
        left_next   = left_reg;
        disc_next   = disc_reg;
        burst       = '0;
        if (direction_reg == akx_pkg::DIR_ENCRYPT)
        begin
            if (frame_start)
            begin
                key_next  = initial_key_reg;
                hidx_next = 3'(akx_pkg::HDR_BYTES);
                if (plen_over)
                begin
                    left_next         = '0;
                    disc_next         = 1'b1;
                    burst.tail_en     = 1'b1;
                    burst.tail_last   = 1'b1;
                    burst.tail_status = akx_pkg::STATUS_OVER_LIMIT;
                end
                else
                begin
                    burst.hdr_en    = 1'b1;
                    burst.hdr_len   = payload_length;
                    burst.hdr_empty = (payload_length == '0);
                    if (payload_length == '0)
                    begin
                        left_next = '0;
                        disc_next = 1'b1;
                    end
                    else
                    begin
                        key_next          = xor_byte;
                        left_next         = left_dec;
                        disc_next         = emit_last;
                        burst.tail_en     = 1'b1;
                        burst.tail_byte   = xor_byte;
                        burst.tail_last   = emit_last;
                        burst.tail_status = akx_pkg::STATUS_DATA;
                    end
                end
            end
            else if (!disc_reg && left_reg != '0)
            begin
                key_next          = xor_byte;
                left_next         = left_dec;
                disc_next         = emit_last;
                burst.tail_en     = 1'b1;
                burst.tail_byte   = xor_byte;
                burst.tail_last   = emit_last;
                burst.tail_status = akx_pkg::STATUS_DATA;
            end
        end
        else
        begin
            key_next    = eff_key;
            hidx_next   = eff_hidx;
            gather_next = eff_gather;
            left_next   = frame_start ? '0 : left_reg;
            disc_next   = frame_start ? 1'b0 : disc_reg;
            if (!disc_next)
            begin
                if (eff_hidx < 3'(akx_pkg::HDR_BYTES))
                begin
                    gather_next = gather_shift;
                    hidx_next   = eff_hidx + 3'd1;
                    if (eff_hidx == 3'(akx_pkg::HDR_BYTES - 1))
                    begin
                        if (gather_over)
                        begin
                            disc_next         = 1'b1;
                            burst.tail_en     = 1'b1;
                            burst.tail_last   = 1'b1;
                            burst.tail_status = akx_pkg::STATUS_OVER_LIMIT;
                        end
                        else if (gather_shift == 32'd0)
                        begin
                            disc_next         = 1'b1;
                            burst.tail_en     = 1'b1;
                            burst.tail_last   = 1'b1;
                            burst.tail_status = akx_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            left_next = gather_shift[CNT_W-1:0];
                        end
                    end
                end
                else if (left_reg == '0)
                begin
                    disc_next = 1'b1;
                end
                else
                begin
                    // ciphertext byte keys the next one
                    key_next          = data_byte;
                    left_next         = left_dec;
                    disc_next         = emit_last;
                    burst.tail_en     = 1'b1;
                    burst.tail_byte   = xor_byte;
                    burst.tail_last   = emit_last;
                    burst.tail_status = akx_pkg::STATUS_DATA;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= akx_pkg::DIR_DECRYPT;
            initial_key_reg <= akx_pkg::INITIAL_KEY_RESET;
            key_reg         <= akx_pkg::INITIAL_KEY_RESET;
            hidx_reg        <= 3'd0;
            gather_reg      <= 32'd0;
            left_reg        <= '0;
            disc_reg        <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == akx_pkg::REG_DIRECTION)
                begin
                    direction_reg <= cfg_data[0];
                end
                else
                begin
                    initial_key_reg <= cfg_data;
                end
            end
            if (accept)
            begin
                key_reg    <= key_next;
                hidx_reg   <= hidx_next;
                gather_reg <= gather_next;
                left_reg   <= left_next;
                disc_reg   <= disc_next;
            end
        end
    end

endmodule

[design/akx_burst.sv]
// result sequencer: holds one item's results and hands them out one per transfer
module akx_burst (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 accept,
    input  akx_pkg::burst_t      burst,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 is_header,
    output logic                 last,
    output akx_pkg::status_t     status
);

    localparam logic [2:0] STEP_TAIL = 3'(akx_pkg::HDR_BYTES);

    akx_pkg::burst_t  b_reg, b_next;
    logic [2:0]       step_reg, step_next;
    logic             pend_reg, pend_next;
    logic             ov_reg, ov_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic             ohdr_reg, ohdr_next;
    logic             olast_reg, olast_next;
    akx_pkg::status_t ost_reg, ost_next;

    logic             out_free;
    logic             is_tail;
    logic [1:0]       hdr_sel;
    logic [1:0]       shift_sel;
    logic [31:0]      hdr_word;
    logic [7:0]       hdr_byte;
    logic             hdr_fin;
    logic             final_item;

    assign out_free   = !ov_reg || !out_stall;
    assign is_tail    = (step_reg == STEP_TAIL);
    assign hdr_sel    = step_reg[1:0];
    assign shift_sel  = 2'd3 - hdr_sel;
    assign hdr_word   = {{(32 - akx_pkg::LEN_W){1'b0}}, b_reg.hdr_len};
    assign hdr_byte   = hdr_word[{shift_sel, 3'b000} +: 8];
    assign hdr_fin    = (hdr_sel == 2'd3);
    assign final_item = is_tail || (hdr_fin && !b_reg.tail_en);
    assign in_stall   = pend_reg && !(out_free && final_item);
    assign accept     = in_valid && !in_stall;

    always_comb
    begin
        b_next     = b_reg;
        step_next  = step_reg;
        pend_next  = pend_reg;
        ov_next    = ov_reg;
        obyte_next = obyte_reg;
        ohdr_next  = ohdr_reg;
        olast_next = olast_reg;
        ost_next   = ost_reg;
        if (out_free)
        begin
            ov_next = pend_reg;
            if (pend_reg)
            begin
                if (is_tail)
                begin
                    obyte_next = b_reg.tail_byte;
                    ohdr_next  = 1'b0;
                    olast_next = b_reg.tail_last;
                    ost_next   = b_reg.tail_status;
                end
                else
                begin
                    obyte_next = hdr_byte;
                    ohdr_next  = 1'b1;
                    olast_next = hdr_fin && b_reg.hdr_empty;
                    ost_next   = (hdr_fin && b_reg.hdr_empty) ? akx_pkg::STATUS_EMPTY
                                                              : akx_pkg::STATUS_DATA;
                end
                if (final_item)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    step_next = hdr_fin ? STEP_TAIL : step_reg + 3'd1;
                end
            end
        end
        if (accept)
        begin
            b_next    = burst;
            step_next = burst.hdr_en ? 3'd0 : STEP_TAIL;
            pend_next = burst.hdr_en || burst.tail_en;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_TAIL;
            pend_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            pend_reg <= pend_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        obyte_reg <= obyte_next;
        ohdr_reg  <= ohdr_next;
        olast_reg <= olast_next;
        ost_reg   <= ost_next;
    end

    assign out_valid = ov_reg;
    assign out_byte  = obyte_reg;
    assign is_header = ohdr_reg;
    assign last      = olast_reg;
    assign status    = ost_reg;

    // no new item while results of the current one remain
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !final_item |-> in_stall)
        else $error("input taken while results still pending");

    a_header_step: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !is_tail |-> b_reg.hdr_en)
        else $error("header step without header in burst");

    a_hdr_status: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ohdr_reg && !olast_reg |-> ost_reg == akx_pkg::STATUS_DATA)
        else $error("non-final header byte carries a status");

    a_over_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ost_reg == akx_pkg::STATUS_OVER_LIMIT |-> olast_reg && obyte_reg == 8'h00)
        else $error("over-limit result malformed");

    a_burst_taken: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (burst.hdr_en || burst.tail_en) |=> pend_reg)
        else $error("burst with results lost");

endmodule

[design/autokey_xor_frame_codec.sv]
// top level of the autokey xor frame codec: length-prefixed framing with autokey xor
// results: an input transfer's results are held in the burst register, then presented from the output register
// throughput: one input transfer per cycle unless the output stalls; the input stalls
//   until an item's last result goes (encrypt start: four header bytes, first ciphertext)
// reset: direction decrypt, initial key 171, frame state discarding until a frame start
// no clearing pass; control flip-flops clear on rst_n, data registers load before use
module autokey_xor_frame_codec #(
    parameter int MAX_PAYLOAD = akx_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write port
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [7:0]                cfg_data,
    // input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                data_byte,
    input  logic                      frame_start,
    input  logic [akx_pkg::LEN_W-1:0] payload_length,
    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                out_byte,
    output logic                      is_header,
    output logic                      last,
    output logic [1:0]                status
);

    // byte counter wide enough for the largest legal payload
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    logic             accept;
    akx_pkg::burst_t  burst;
    akx_pkg::status_t status_int;

    // codec state advances on every input transfer and produces the burst of results
    akx_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CNT_W       (CNT_W)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .accept         (accept),
        .data_byte      (data_byte),
        .frame_start    (frame_start),
        .payload_length (payload_length),
        .burst          (burst)
    );

    // burst register plus output register; a single-result item leaves as the next is taken
    // so the input keeps taking a byte per cycle while the output is not stalled
    akx_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .accept    (accept),
        .burst     (burst),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .is_header (is_header),
        .last      (last),
        .status    (status_int)
    );

    assign status = status_int;

endmodule

[tb/sv/autokey_xor_frame_codec_test.sv]
// self-checking testbench for the autokey xor frame codec
`timescale 1ns / 100ps

module autokey_xor_frame_codec_test;

    localparam int PAYLOAD_CAP    = akx_pkg::MAX_PAYLOAD_DEFAULT;
    localparam int LEN_W          = akx_pkg::LEN_W;
    localparam int HDR_BYTES      = akx_pkg::HDR_BYTES;
    localparam int RANDOM_ITEMS   = 82;
    localparam int CYCLE_LIMIT    = 400000;
    // a transfer that causes no result may still be in flight after the last owed result
    localparam int DRAIN_CYCLES   = 4;
    localparam int SQUEEZE_CYCLES = 120;

    // one result of the codec
    typedef struct packed {
        logic [7:0]       val;
        logic             hdr;
        logic             eof;
        akx_pkg::status_t st;
    } codec_out_t;

    // how a directed row gets its expectation
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } row_check_t;

    typedef enum logic {
        ROW_REGS,
        ROW_ITEM
    } row_kind_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        STALL_FLOW,
        STALL_SPARSE,
        STALL_HALF,
        STALL_CADENCE
    } stall_mode_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             dir;
        logic [7:0]       key;
        logic [7:0]       data;
        logic             start;
        logic [LEN_W-1:0] plen;
        row_check_t       chk;
        codec_out_t       typed;
    } step_row_t;

    localparam codec_out_t NO_RESULT    = '0;
    localparam codec_out_t OVER_RESULT  = {8'h00, 1'b0, 1'b1, akx_pkg::STATUS_OVER_LIMIT};
    localparam codec_out_t EMPTY_RESULT = {8'h00, 1'b0, 1'b1, akx_pkg::STATUS_EMPTY};

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    logic             cfg_index;
    logic [7:0]       cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       data_byte;
    logic             frame_start;
    logic [LEN_W-1:0] payload_length;
    logic             out_valid;
    logic             out_stall;
    logic [7:0]       out_byte;
    logic             is_header;
    logic             last;
    logic [1:0]       status;

    autokey_xor_frame_codec #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .frame_start    (frame_start),
        .payload_length (payload_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_header      (is_header),
        .last           (last),
        .status         (status)
    );

    // predictor copy of the registers and the frame state
    logic             mdl_dir;
    logic [7:0]       mdl_init_key;
    logic [7:0]       mdl_key;
    logic [2:0]       mdl_hdr_cnt;
    logic [31:0]      mdl_len;
    logic [LEN_W-1:0] mdl_left;
    bit               mdl_dropping;

    // results of the latest transfer, then the queue of results still owed by the codec
    codec_out_t       forecast [0:4];
    int               forecast_n;
    codec_out_t       awaited_bytes [$];
    step_row_t        directed_steps [$];

    int               errors;
    int               transfers;
    int               results_checked;
    int               enc_frames;
    int               dec_frames;
    int               random_sent;
    int               burst_left;
    int               cycles;
    bit               squeeze_req;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle counter and run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, awaited_bytes.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void add_forecast(input logic [7:0] v, input logic h, input logic e,
                                         input akx_pkg::status_t s);
        forecast[forecast_n] = {v, h, e, s};
        forecast_n++;
    endfunction

    // one payload byte through the autokey xor; ciphertext becomes the next key
    function automatic void cipher_byte(input logic [7:0] b, input logic enc);
        logic [7:0] res;
        res      = b ^ mdl_key;
        mdl_key  = enc ? res : b;
        mdl_left = mdl_left - 1'b1;
        if (mdl_left == 0)
            mdl_dropping = 1'b1;
        add_forecast(res, 1'b0, mdl_left == 0, akx_pkg::STATUS_DATA);
    endfunction

    // advance the frame state by one accepted transfer, filling forecast
    function automatic void forecast_transfer(input logic [7:0] b, input logic start,
                                              input logic [LEN_W-1:0] plen);
        logic [31:0] wide;
        int          i;
        forecast_n = 0;
        if (mdl_dir == akx_pkg::DIR_ENCRYPT)
        begin
            if (!start)
            begin
                // body byte, or nothing once the frame is done or dropped
                if (!mdl_dropping && mdl_left != 0)
                    cipher_byte(b, 1'b1);
                return;
            end
            enc_frames++;
            mdl_key     = mdl_init_key;
            mdl_hdr_cnt = 3'(HDR_BYTES);
            mdl_len     = {{(32 - LEN_W){1'b0}}, plen};
            if (plen > PAYLOAD_CAP)
            begin
                // over limit: lone status result, frame dropped
                mdl_left     = '0;
                mdl_dropping = 1'b1;
                add_forecast(8'h00, 1'b0, 1'b1, akx_pkg::STATUS_OVER_LIMIT);
                return;
            end
            // big-endian length header
            wide = {{(32 - LEN_W){1'b0}}, plen};
            for (i = 0; i < HDR_BYTES; i++)
            begin
                if (plen == 0 && i == HDR_BYTES - 1)
                    add_forecast(wide[31 - 8 * i -: 8], 1'b1, 1'b1, akx_pkg::STATUS_EMPTY);
                else
                    add_forecast(wide[31 - 8 * i -: 8], 1'b1, 1'b0, akx_pkg::STATUS_DATA);
            end
            mdl_left = plen;
            if (plen == 0)
            begin
                mdl_dropping = 1'b1;
                return;
            end
            mdl_dropping = 1'b0;
            cipher_byte(b, 1'b1);
            return;
        end

        // decrypt: a frame start restarts header gathering
        if (start)
        begin
            dec_frames++;
            mdl_key      = mdl_init_key;
            mdl_hdr_cnt  = '0;
            mdl_len      = '0;
            mdl_left     = '0;
            mdl_dropping = 1'b0;
        end
        if (mdl_dropping)
            return;
        if (mdl_hdr_cnt < HDR_BYTES)
        begin
            mdl_len     = {mdl_len[23:0], b};
            mdl_hdr_cnt = mdl_hdr_cnt + 1'b1;
            if (mdl_hdr_cnt < HDR_BYTES)
                return;
            if (mdl_len > PAYLOAD_CAP)
            begin
                mdl_dropping = 1'b1;
                add_forecast(8'h00, 1'b0, 1'b1, akx_pkg::STATUS_OVER_LIMIT);
                return;
            end
            if (mdl_len == 0)
            begin
                mdl_dropping = 1'b1;
                add_forecast(8'h00, 1'b0, 1'b1, akx_pkg::STATUS_EMPTY);
                return;
            end
            mdl_left = mdl_len[LEN_W-1:0];
            return;
        end
        // bytes past the declared length end the frame silently
        if (mdl_left == 0)
        begin
            mdl_dropping = 1'b1;
            return;
        end
        cipher_byte(b, 1'b0);
    endfunction

    function automatic void regs_row(input logic dir, input logic [7:0] key);
        step_row_t r;
        r              = '0;
        r.kind         = ROW_REGS;
        r.dir          = dir;
        r.key          = key;
        directed_steps = {directed_steps, r};
    endfunction

    function automatic void item_row(input logic [7:0] b, input logic s,
                                     input logic [LEN_W-1:0] p, input row_check_t c,
                                     input codec_out_t t);
        step_row_t r;
        r              = '0;
        r.kind         = ROW_ITEM;
        r.data         = b;
        r.start        = s;
        r.plen         = p;
        r.chk          = c;
        r.typed        = t;
        directed_steps = {directed_steps, r};
    endfunction

    // offer one transfer in bursts with random gaps; record what it owes once accepted
    task automatic send_item(input logic [7:0] b, input logic start,
                             input logic [LEN_W-1:0] plen, input row_check_t chk,
                             input codec_out_t typed);
        int gap;
        int i;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        frame_start    <= start;
        payload_length <= plen;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transfer taken at this edge
        burst_left--;
        transfers++;
        forecast_transfer(b, start, plen);
        if (chk == CHK_MODEL)
        begin
            for (i = 0; i < forecast_n; i++)
                awaited_bytes = {awaited_bytes, forecast[i]};
        end
        else if (chk == CHK_ONE)
        begin
            awaited_bytes = {awaited_bytes, typed};
        end
    endtask

    // stop offering and wait until the codec owes nothing and has drained
    task automatic settle();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (awaited_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // both registers, back to back, write enable held across them
    task automatic write_regs(input logic dir, input logic [7:0] key);
        cfg_write <= 1'b1;
        cfg_index <= akx_pkg::REG_DIRECTION;
        cfg_data  <= {7'b0, dir};
        @(posedge clk);
        mdl_dir    = dir;
        cfg_index <= akx_pkg::REG_INITIAL_KEY;
        cfg_data  <= key;
        @(posedge clk);
        mdl_init_key = key;
        cfg_write   <= 1'b0;
    endtask

    // mostly well-formed frames with random content, some truncated, overlong or noisy
    task automatic random_frame(input logic dir);
        int               pick;
        int               body;
        int               hdr_sent;
        int               i;
        logic [31:0]      len32;
        logic [LEN_W-1:0] plen;
        // stray byte between frames
        if ($urandom_range(0, 19) == 0)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0,
                      LEN_W'($urandom_range(0, (1 << LEN_W) - 1)), CHK_MODEL, NO_RESULT);
            random_sent++;
        end
        pick     = $urandom_range(0, 99);
        hdr_sent = HDR_BYTES;
        if (dir == akx_pkg::DIR_ENCRYPT)
        begin
            if (pick < 8)
                plen = '0;
            else if (pick < 16)
                plen = LEN_W'($urandom_range(PAYLOAD_CAP + 1, (1 << LEN_W) - 1));
            else if (pick < 20)
                plen = LEN_W'(PAYLOAD_CAP);
            else
                plen = LEN_W'($urandom_range(1, 8));
            len32 = {{(32 - LEN_W){1'b0}}, plen};
            send_item(8'($urandom_range(0, 255)), 1'b1, plen, CHK_MODEL, NO_RESULT);
            random_sent++;
        end
        else
        begin
            if (pick < 8)
                len32 = '0;
            else if (pick < 16)
                len32 = $urandom_range(PAYLOAD_CAP + 1, 32'hFFFF_FFFF);
            else if (pick < 20)
                len32 = PAYLOAD_CAP;
            else
                len32 = $urandom_range(1, 8);
            // occasionally cut the header short; the next frame start abandons it
            if (pick >= 20 && pick < 25)
                hdr_sent = $urandom_range(1, HDR_BYTES - 1);
            for (i = 0; i < hdr_sent; i++)
            begin
                send_item(len32[31 - 8 * i -: 8], i == 0,
                          LEN_W'($urandom_range(0, (1 << LEN_W) - 1)), CHK_MODEL, NO_RESULT);
                random_sent++;
            end
        end
        if (hdr_sent < HDR_BYTES)
        begin
            body = 0;
        end
        else if (len32 >= 1 && len32 <= 8)
        begin
            body = len32;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                body = $urandom_range(0, body - 1);     // frame abandoned early
            else if (pick < 25)
                body = body + $urandom_range(1, 3);     // trailing bytes past the end
        end
        else
        begin
            body = $urandom_range(0, 3);
        end
        for (i = 0; i < body; i++)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0,
                      LEN_W'($urandom_range(0, (1 << LEN_W) - 1)), CHK_MODEL, NO_RESULT);
            random_sent++;
        end
    endtask

    // receiver: changing stall patterns, plus one long hold-off to back the codec up
    initial
    begin
        int          hold_left;
        int          mode_left;
        bit          squeeze_done;
        stall_mode_t mode;
        hold_left    = 0;
        mode_left    = 0;
        squeeze_done = 1'b0;
        mode         = STALL_FLOW;
        out_stall   <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                hold_left    = SQUEEZE_CYCLES - 1;
                out_stall   <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(4, 40);
                    mode      = stall_mode_t'($urandom_range(0, 3));
                end
                mode_left--;
                case (mode)
                    STALL_FLOW:   out_stall <= 1'b0;
                    STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HALF:   out_stall <= 1'($urandom_range(0, 1));
                    default:      out_stall <= (mode_left % 3 != 0);
                endcase
            end
        end
    end

    // result checker: every result transfer against the oldest owed result
    always @(posedge clk)
    begin
        codec_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_bytes.size() == 0)
            begin
                $error("unexpected result: out_byte %02h is_header %0b last %0b status %0d",
                       out_byte, is_header, last, status);
                errors++;
            end
            else
            begin
                want = awaited_bytes.pop_front();
                results_checked++;
                if (out_byte !== want.val)
                begin
                    $error("out_byte: expected %02h, got %02h", want.val, out_byte);
                    errors++;
                end
                if (is_header !== want.hdr)
                begin
                    $error("is_header: expected %0b, got %0b", want.hdr, is_header);
                    errors++;
                end
                if (last !== want.eof)
                begin
                    $error("last: expected %0b, got %0b", want.eof, last);
                    errors++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int          i;
        int          phase;
        int          phase_end;
        logic        phase_dir;
        logic [7:0]  phase_key;

        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= akx_pkg::REG_DIRECTION;
        cfg_data       <= 8'h00;
        in_valid       <= 1'b0;
        data_byte      <= 8'h00;
        frame_start    <= 1'b0;
        payload_length <= '0;
        errors          = 0;
        transfers       = 0;
        results_checked = 0;
        enc_frames      = 0;
        dec_frames      = 0;
        random_sent     = 0;
        burst_left      = 0;
        cycles          = 0;
        squeeze_req     = 1'b0;

        // predictor at reset: decrypt, key 171, dropping until a frame start
        mdl_dir      = akx_pkg::DIR_DECRYPT;
        mdl_init_key = akx_pkg::INITIAL_KEY_RESET;
        mdl_key      = akx_pkg::INITIAL_KEY_RESET;
        mdl_hdr_cnt  = '0;
        mdl_len      = '0;
        mdl_left     = '0;
        mdl_dropping = 1'b1;

        // directed table, reset defaults first
        // byte before any frame start is ignored
        item_row(8'h55, 1'b0, 14'h3FFF, CHK_NONE, NO_RESULT);
        // decrypt a two byte frame, length field ignored, then one byte past the end
        item_row(8'h00, 1'b1, 14'h3FFF, CHK_NONE, NO_RESULT);
        item_row(8'h00, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'h00, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'h02, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'hFF, 1'b0, 14'h0000, CHK_MODEL, NO_RESULT);
        item_row(8'h00, 1'b0, 14'h0000, CHK_MODEL, NO_RESULT);
        item_row(8'h12, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        // largest declared length is over the limit; the following byte is dropped
        item_row(8'hFF, 1'b1, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'hFF, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'hFF, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'hFF, 1'b0, 14'h0000, CHK_ONE, OVER_RESULT);
        item_row(8'h77, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        // declared length zero
        item_row(8'h00, 1'b1, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'h00, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'h00, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'h00, 1'b0, 14'h0000, CHK_ONE, EMPTY_RESULT);
        // declared length right at the limit, frame left open
        item_row(8'h00, 1'b1, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'h00, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'h20, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'h00, 1'b0, 14'h0000, CHK_NONE, NO_RESULT);
        item_row(8'hA5, 1'b0, 14'h0000, CHK_MODEL, NO_RESULT);
        // direction flipped inside that frame: counters carry on under encrypt
        regs_row(akx_pkg::DIR_ENCRYPT, 8'hFF);
        item_row(8'h3C, 1'b0, 14'h0000, CHK_MODEL, NO_RESULT);
        // encrypt frame of three, header plus first ciphertext on the start transfer
        item_row(8'hFF, 1'b1, 14'd3, CHK_MODEL, NO_RESULT);
        item_row(8'h00, 1'b0, 14'h0000, CHK_MODEL, NO_RESULT);
        regs_row(akx_pkg::DIR_ENCRYPT, 8'h00);
        // empty payload, longest length field, length at the limit
        item_row(8'h81, 1'b1, 14'h0000, CHK_MODEL, NO_RESULT);
        item_row(8'h00, 1'b1, 14'h3FFF, CHK_ONE, OVER_RESULT);
        item_row(8'h5A, 1'b1, LEN_W'(PAYLOAD_CAP), CHK_MODEL, NO_RESULT);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < directed_steps.size(); i++)
        begin
            if (directed_steps[i].kind == ROW_REGS)
            begin
                settle();
                write_regs(directed_steps[i].dir, directed_steps[i].key);
            end
            else
            begin
                send_item(directed_steps[i].data, directed_steps[i].start,
                          directed_steps[i].plen, directed_steps[i].chk,
                          directed_steps[i].typed);
            end
        end

        // random phases: direction alternates, key at both extremes then random
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            phase_dir = (phase % 2 == 0) ? akx_pkg::DIR_DECRYPT : akx_pkg::DIR_ENCRYPT;
            if (phase == 0)
                phase_key = 8'h00;
            else if (phase == 1)
                phase_key = 8'hFF;
            else
                phase_key = 8'($urandom_range(0, 255));
            write_regs(phase_dir, phase_key);
            // long receiver hold-off while the sender keeps offering
            if (phase == 0)
                squeeze_req = 1'b1;
            phase_end = random_sent + $urandom_range(18, 30);
            if (phase_end > RANDOM_ITEMS)
                phase_end = RANDOM_ITEMS;
            while (random_sent < phase_end)
                random_frame(phase_dir);
            phase++;
        end

        settle();
        repeat (8) @(posedge clk);

        if (awaited_bytes.size() != 0)
        begin
            $error("%0d results never arrived", awaited_bytes.size());
            errors++;
        end
        $display("covered %0d transfers over %0d encrypt and %0d decrypt frames in %0d phases",
                 transfers, enc_frames, dec_frames, phase);
        $display("checked %0d results, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
